>>> rtl/idr_pkg.sv
// shared types and constants for the 32-bit divider pipeline
`timescale 1ns / 1ps
`default_nettype none
package idr_pkg;

    localparam int WORD_W = 32;

    typedef enum logic [1:0] {
        CMD_UQUO = 2'd0,
        CMD_UREM = 2'd1,
        CMD_SQUO = 2'd2,
        CMD_SREM = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd cmd;
        logic num_neg;
        logic den_neg;
        logic den_zero;
    } t_side;

    typedef struct packed {
        logic [WORD_W-1:0] rem;
        logic [WORD_W-1:0] numq;
        logic [WORD_W-1:0] den;
        t_side             side;
    } t_cell_data;

endpackage
`default_nettype wire

>>> rtl/idr_prep.sv
// entry stage: takes operand magnitudes and records signs for the divider chain
`timescale 1ns / 1ps
`default_nettype none
module idr_prep (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire idr_pkg::t_cmd             i_cmd,
    input  wire logic [idr_pkg::WORD_W-1:0] i_dividend,
    input  wire logic [idr_pkg::WORD_W-1:0] i_divisor,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output idr_pkg::t_cell_data            o_data
);
    import idr_pkg::*;

    logic       r_valid;
    t_cell_data r_data;
    t_cell_data n_data;
    logic       is_signed;

    assign is_signed = (i_cmd == CMD_SQUO) || (i_cmd == CMD_SREM);

    always_comb begin
        n_data               = '0;
        n_data.side.cmd      = i_cmd;
        n_data.side.num_neg  = is_signed & i_dividend[WORD_W-1];
        n_data.side.den_neg  = is_signed & i_divisor[WORD_W-1];
        n_data.side.den_zero = (i_divisor == '0);
        n_data.rem           = '0;
        n_data.numq          = n_data.side.num_neg ? (-i_dividend) : i_dividend;
        n_data.den           = n_data.side.den_neg ? (-i_divisor) : i_divisor;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
`default_nettype wire

>>> rtl/idr_cell.sv
// one restoring shift-and-subtract step, one quotient bit per cell
`timescale 1ns / 1ps
`default_nettype none
module idr_cell (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire idr_pkg::t_cell_data  i_data,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output idr_pkg::t_cell_data       o_data
);
    import idr_pkg::*;

    logic              r_valid;
    t_cell_data        r_data;
    t_cell_data        n_data;
    logic [WORD_W-1:0] shifted;
    logic [WORD_W:0]   diff;
    logic              fits;

    assign shifted = {i_data.rem[WORD_W-2:0], i_data.numq[WORD_W-1]};
    assign diff    = {1'b0, shifted} - {1'b0, i_data.den};
    assign fits    = !diff[WORD_W];

    always_comb begin
        n_data      = i_data;
        n_data.rem  = fits ? diff[WORD_W-1:0] : shifted;
        n_data.numq = {i_data.numq[WORD_W-2:0], fits};
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
`default_nettype wire

>>> rtl/idr_post.sv
// exit stage: picks quotient or remainder, restores sign, holds the result item
`timescale 1ns / 1ps
`default_nettype none
module idr_post (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire idr_pkg::t_cell_data        i_data,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic [idr_pkg::WORD_W-1:0]      o_result
);
    import idr_pkg::*;

    logic              r_valid;
    logic [WORD_W-1:0] r_result;
    logic [WORD_W-1:0] n_result;
    logic [WORD_W-1:0] quo;
    logic [WORD_W-1:0] rem;

    assign quo = i_data.numq;
    assign rem = i_data.rem;

    always_comb begin
        case (i_data.side.cmd)
            CMD_UQUO: n_result = quo;
            CMD_UREM: n_result = rem;
            CMD_SQUO: n_result = (i_data.side.num_neg ^ i_data.side.den_neg) ?
                                 (-quo) : quo;
            CMD_SREM: n_result = i_data.side.num_neg ? (-rem) : rem;
            default:  n_result = '0;
        endcase
        if (i_data.side.den_zero) begin
            n_result = '0;
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule
`default_nettype wire

>>> rtl/int32_divide_remainder.sv
// top level of the pipelined 32-bit signed and unsigned divider
//
// Pipelined restoring divider: an entry stage forms operand magnitudes, a row of
// 32 cells each works out one quotient bit with one 33-bit subtract and compare,
// and an exit stage selects quotient or remainder, fixes its sign and holds the
// result item. One item is accepted per cycle while o_ready is high; o_ready
// drops once a stalled output has filled every stage. Every stage has its own
// valid bit and moves whenever the stage after it is empty or moving, so
// bubbles close up while the output is stalled. cmd: 0 unsigned quotient,
// 1 unsigned remainder, 2 signed quotient, 3 signed remainder; signed division
// truncates toward zero and a zero divisor gives 0.
`timescale 1ns / 1ps
`default_nettype none
module int32_divide_remainder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [31:0] i_dividend,
    input  wire logic [31:0] i_divisor,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_result
);
    import idr_pkg::*;

    t_cell_data chain_data  [0:WORD_W];
    logic       chain_valid [0:WORD_W];
    logic       chain_ready [0:WORD_W];

    idr_prep u_prep (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_cmd      (t_cmd'(i_cmd)),
        .i_dividend (i_dividend),
        .i_divisor  (i_divisor),
        .o_valid    (chain_valid[0]),
        .i_ready    (chain_ready[0]),
        .o_data     (chain_data[0])
    );

    for (genvar k = 0; k < WORD_W; k++) begin : g_cell
        idr_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (chain_valid[k]),
            .o_ready (chain_ready[k]),
            .i_data  (chain_data[k]),
            .o_valid (chain_valid[k+1]),
            .i_ready (chain_ready[k+1]),
            .o_data  (chain_data[k+1])
        );
    end

    idr_post u_post (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (chain_valid[WORD_W]),
        .o_ready  (chain_ready[WORD_W]),
        .i_data   (chain_data[WORD_W]),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (o_result)
    );

endmodule
`default_nettype wire

>>> bench/idr_result_checker.sv
// result checker for the 32-bit divider: predicts each quotient or remainder and compares
`timescale 1ns / 1ps
module idr_result_checker
    import idr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [31:0] i_dividend,
    input  wire logic [31:0] i_divisor,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [31:0] i_result,
    output int               o_mismatch_count,
    output int               o_words_due
);

    typedef struct {
        t_cmd              op;
        logic [WORD_W-1:0] num;
        logic [WORD_W-1:0] den;
        logic [WORD_W-1:0] word;
    } t_due;

    t_due words_due[$];
    int   mismatch_count = 0;

    assign o_mismatch_count = mismatch_count;

    initial o_words_due = 0;

    function automatic logic [WORD_W-1:0] divide_word(t_cmd op, logic [WORD_W-1:0] num,
                                                      logic [WORD_W-1:0] den);
        logic              signed_mode;
        logic              num_neg;
        logic              den_neg;
        logic [WORD_W-1:0] mag_num;
        logic [WORD_W-1:0] mag_den;
        logic [WORD_W-1:0] quo;
        logic [WORD_W-1:0] rem;
        logic [WORD_W:0]   part;
        int                b;
        signed_mode = (op == CMD_SQUO) || (op == CMD_SREM);
        num_neg     = signed_mode && num[WORD_W-1];
        den_neg     = signed_mode && den[WORD_W-1];
        mag_num     = num_neg ? -num : num;
        mag_den     = den_neg ? -den : den;
        if (mag_den == '0) begin
            return '0;
        end
        quo = '0;
        rem = '0;
        for (b = WORD_W - 1; b >= 0; b--) begin
            part = {rem, mag_num[b]};
            if (part >= {1'b0, mag_den}) begin
                part   = part - {1'b0, mag_den};
                quo[b] = 1'b1;
            end
            rem = part[WORD_W-1:0];
        end
        case (op)
            CMD_UQUO: return quo;
            CMD_UREM: return rem;
            CMD_SQUO: return (num_neg != den_neg) ? -quo : quo;
            default:  return num_neg ? -rem : rem;
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t checker: %s", $realtime, msg);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        t_due due;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready) begin
                due.op   = t_cmd'(i_cmd);
                due.num  = i_dividend;
                due.den  = i_divisor;
                due.word = divide_word(due.op, i_dividend, i_divisor);
                words_due.push_back(due);
            end
            if (i_out_valid && i_out_ready) begin
                if (words_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %h", i_result));
                end else begin
                    due = words_due.pop_front();
                    if (i_result !== due.word) begin
                        report_mismatch($sformatf("%s %h / %h: got %h, want %h",
                                        due.op.name(), due.num, due.den, i_result, due.word));
                    end
                end
            end
        end
        o_words_due <= words_due.size();
    end

endmodule

>>> bench/tb.sv
// testbench top for the 32-bit divider: stimulus, handshake idling and verdict
`timescale 1ns / 1ps
module tb;
    import idr_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_cmd = CMD_UQUO;
    logic [31:0] i_dividend = '0;
    logic [31:0] i_divisor = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [31:0] o_result;

    int mismatch_count;
    int words_due;
    bit idling_on = 1'b0;
    int stall_left = 0;

    always #5 i_clk = ~i_clk;

    int32_divide_remainder uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_cmd      (i_cmd),
        .i_dividend (i_dividend),
        .i_divisor  (i_divisor),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_result   (o_result)
    );

    idr_result_checker checker_i (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_valid),
        .i_in_ready       (o_ready),
        .i_cmd            (i_cmd),
        .i_dividend       (i_dividend),
        .i_divisor        (i_divisor),
        .i_out_valid      (o_valid),
        .i_out_ready      (i_ready),
        .i_result         (o_result),
        .o_mismatch_count (mismatch_count),
        .o_words_due      (words_due)
    );

    // receiver stalls in short bursts
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_ready    <= 1'b0;
        end else if (idling_on && $urandom_range(0, 3) == 0) begin
            stall_left <= $urandom_range(0, 3);
            i_ready    <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_division(input t_cmd op, input logic [31:0] num, input logic [31:0] den);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_cmd      <= op;
        i_dividend <= num;
        i_divisor  <= den;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 11))
            0:       return 32'h0000_0000;
            1:       return 32'h8000_0000;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0001;
            4, 5, 6: return $urandom >> $urandom_range(0, 31);
            7, 8:    return -($urandom >> $urandom_range(0, 31));
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random(input int count);
        logic [31:0] num;
        logic [31:0] den;
        repeat (count) begin
            num = pick_operand();
            den = pick_operand();
            // dividend close to a multiple of the divisor
            if ($urandom_range(0, 5) == 0) begin
                num = den * ($urandom >> $urandom_range(0, 31)) + $urandom_range(0, 2) - 1;
            end
            send_division(t_cmd'($urandom_range(0, 3)), num, den);
        end
    endtask

    initial begin
        logic [31:0] corner_num[6] = '{32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFF9,
                                       32'h0000_0007, 32'hFFFF_FFF9, 32'h0000_0000};
        logic [31:0] corner_den[6] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0002,
                                       32'hFFFF_FFFE, 32'hFFFF_FFFE, 32'hFFFF_FFFB};
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // zero divisor, most negative over minus one, mixed and both-negative signs, zero dividend
        for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 6; k++) begin
                send_division(t_cmd'(c), corner_num[k], corner_den[k]);
            end
        end

        idling_on = 1'b1;
        send_random(500);
        idling_on = 1'b0;
        send_random(200);

        // drain the pipe completely before going on
        i_valid <= 1'b0;
        do @(negedge i_clk); while (words_due != 0);

        idling_on = 1'b1;
        send_random(500);
        idling_on = 1'b0;
        send_random(220);

        i_valid <= 1'b0;
        do @(negedge i_clk); while (words_due != 0);
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tb: FAIL");
        $finish;
    end

endmodule
